// ===== src/b64d_pkg.sv =====
// Shared types, status codes and the alphabet decode for the base64 stream decoder.
`timescale 1ns / 1ps

package b64d_pkg;

	localparam logic [2:0] ST_OK             = 3'd0;
	localparam logic [2:0] ST_BAD_CHAR       = 3'd1;
	localparam logic [2:0] ST_DATA_AFTER_PAD = 3'd2;
	localparam logic [2:0] ST_TOO_MANY_PADS  = 3'd3;
	localparam logic [2:0] ST_CAPACITY       = 3'd4;
	localparam logic [2:0] ST_INCOMPLETE     = 3'd5;

	localparam logic OP_CHAR   = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_PAD   = 8'h3d;

	// One pending output record: up to three data bytes, or one status result.
	typedef struct packed {
		logic        is_status;
		logic [23:0] bytes;
		logic [1:0]  last_idx;
		logic [2:0]  status;
		logic [15:0] base;
	} res_entry_t;

	typedef struct packed {
		logic       valid;
		logic [5:0] value;
	} sextet_t;

	function automatic sextet_t sextet_decode(input logic [7:0] ch);
		sextet_t r;
		r.valid = 1'b1;
		r.value = 6'd0;
		if (ch >= 8'h41 && ch <= 8'h5a) begin
			r.value = 6'(ch - 8'h41);
		end else if (ch >= 8'h61 && ch <= 8'h7a) begin
			r.value = 6'(ch - 8'h61 + 8'd26);
		end else if (ch >= 8'h30 && ch <= 8'h39) begin
			r.value = 6'(ch - 8'h30 + 8'd52);
		end else if (ch == 8'h2b) begin
			r.value = 6'd62;
		end else if (ch == 8'h2f) begin
			r.value = 6'd63;
		end else begin
			r.valid = 1'b0;
		end
		return r;
	endfunction

endpackage

// ===== src/b64d_if.sv =====
// Handshake channels of the base64 stream decoder: characters, results, configuration.
`timescale 1ns / 1ps

interface b64d_char_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] in_char;
	modport source (output valid, output op, output in_char, input ready);
	modport sink   (input valid, input op, input in_char, output ready);
endinterface

interface b64d_res_if;
	logic        valid;
	logic        ready;
	logic        is_status;
	logic [7:0]  data_byte;
	logic [2:0]  status;
	logic [15:0] byte_count;
	logic        last;
	modport source (output valid, output is_status, output data_byte, output status,
		output byte_count, output last, input ready);
	modport sink   (input valid, input is_status, input data_byte, input status,
		input byte_count, input last, output ready);
endinterface

interface b64d_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== src/base64_stream_decoder.sv =====
// Base64 stream decoder: one character per item in, data bytes and a status result out.
//
// Channels: chars carries op and in_char; op set marks the end of a string. results
// carries decoded bytes (is_status low) and one status result per finish item, which
// reports the sticky error (or incomplete) and byte count, then clears string state.
// cfg writes output_capacity (reset 65535) and is always ready; write it only idle.
// Whitespace, characters after an error and characters after a padded group give
// no result.
// Throughput: one character item a cycle while chars.ready is high. Each item is
// decoded in the cycle it is accepted; a completed group or finish loads a record
// into a two-deep result buffer that is unpacked one result a cycle while results.ready
// is high, so a group of four characters yields up to three bytes at the pace it arrives.
// Latency: the first result of an item appears the cycle after acceptance when the
// buffer is empty. chars.ready falls only while both buffer records are held, which
// happens when the receiver stalls or a finish arrives before a group's bytes are out.
// Reset clears all string state and the buffer; output_capacity returns to 65535.
`timescale 1ns / 1ps

module base64_stream_decoder (
	input  logic            clk,
	input  logic            arst_n,
	b64d_char_if.sink       chars,
	b64d_res_if.source      results,
	b64d_cfg_if.sink        cfg
);

	logic [15:0] cap_q;
	logic [23:0] acc_q;
	logic [1:0]  pos_q;
	logic [2:0]  pad_q;
	logic        stop_q;
	logic [2:0]  err_q;
	logic [15:0] count_q;

	b64d_pkg::res_entry_t cur_q, nxt_q;
	logic                 cur_v_q, nxt_v_q;
	logic [1:0]           sub_q;

	// Next-state of the string decoder
	logic [23:0] acc_d;
	logic [1:0]  pos_d;
	logic [2:0]  pad_d;
	logic        stop_d;
	logic [2:0]  err_d;
	logic [15:0] count_d;
	logic        push;
	b64d_pkg::res_entry_t push_e;

	b64d_pkg::sextet_t sx;
	logic [2:0]  pad_inc;
	logic [23:0] acc_sh;
	logic        in_acc;
	logic        ws;

	assign chars.ready = !nxt_v_q;
	assign in_acc      = chars.valid && chars.ready;
	assign cfg.ready   = 1'b1;

	assign sx        = b64d_pkg::sextet_decode(chars.in_char);
	assign pad_inc   = pad_q + 3'd1;
	assign ws        = chars.in_char == b64d_pkg::CH_CR || chars.in_char == b64d_pkg::CH_LF ||
		chars.in_char == b64d_pkg::CH_SPACE || chars.in_char == b64d_pkg::CH_TAB;

	always_comb begin
		acc_d   = acc_q;
		pos_d   = pos_q;
		pad_d   = pad_q;
		stop_d  = stop_q;
		err_d   = err_q;
		count_d = count_q;
		push    = 1'b0;
		acc_sh  = acc_q;
		push_e  = '0;
		if (chars.op == b64d_pkg::OP_FINISH) begin
			push             = 1'b1;
			push_e.is_status = 1'b1;
			push_e.base      = count_q;
			push_e.status    = (err_q == b64d_pkg::ST_OK && pos_q != 2'd0) ?
				b64d_pkg::ST_INCOMPLETE : err_q;
			acc_d   = '0;
			pos_d   = '0;
			pad_d   = '0;
			stop_d  = 1'b0;
			err_d   = b64d_pkg::ST_OK;
			count_d = '0;
		end else if (err_q == b64d_pkg::ST_OK && !stop_q && !ws) begin
			if (chars.in_char == b64d_pkg::CH_PAD) begin
				pad_d  = pad_inc;
				acc_sh = {acc_q[17:0], 6'd0};
			end else if (pad_q != 3'd0) begin
				err_d = b64d_pkg::ST_DATA_AFTER_PAD;
			end else if (!sx.valid) begin
				err_d = b64d_pkg::ST_BAD_CHAR;
			end else begin
				acc_sh = {acc_q[17:0], sx.value};
			end
			if (err_d == b64d_pkg::ST_OK) begin
				acc_d = acc_sh;
				if (pos_q != 2'd3) begin
					pos_d = pos_q + 2'd1;
				end else begin
					pos_d = 2'd0;
					if (pad_d >= 3'd3) begin
						err_d = b64d_pkg::ST_TOO_MANY_PADS;
					end else begin
						// pad_d is 0..2 here; recompute byte count from it
						if (count_q + 17'(3'd3 - pad_d) > {1'b0, cap_q}) begin
							err_d = b64d_pkg::ST_CAPACITY;
						end else begin
							push             = 1'b1;
							push_e.bytes     = acc_sh;
							push_e.last_idx  = 2'(3'd2 - pad_d);
							push_e.base      = count_q;
							count_d          = 16'(count_q + 17'(3'd3 - pad_d));
							acc_d            = '0;
							stop_d           = pad_d != 3'd0;
						end
					end
				end
			end
		end
	end

	// Result buffer: cur is being unpacked, nxt waits behind it
	logic cur_done;
	logic cur_free;
	assign cur_done = cur_v_q && results.ready && sub_q == cur_q.last_idx;
	assign cur_free = cur_done || !cur_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= 16'hffff;
			acc_q   <= '0;
			pos_q   <= '0;
			pad_q   <= '0;
			stop_q  <= 1'b0;
			err_q   <= b64d_pkg::ST_OK;
			count_q <= '0;
			cur_v_q <= 1'b0;
			nxt_v_q <= 1'b0;
			sub_q   <= '0;
		end else begin
			if (cfg.valid) begin
				cap_q <= cfg.data;
			end
			if (in_acc) begin
				acc_q   <= acc_d;
				pos_q   <= pos_d;
				pad_q   <= pad_d;
				stop_q  <= stop_d;
				err_q   <= err_d;
				count_q <= count_d;
			end
			if (cur_free) begin
				sub_q <= '0;
				if (nxt_v_q) begin
					cur_v_q <= 1'b1;
					nxt_v_q <= in_acc && push;
				end else begin
					cur_v_q <= in_acc && push;
				end
			end else begin
				if (results.ready) begin
					sub_q <= sub_q + 2'd1;
				end
				if (in_acc && push) begin
					nxt_v_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cur_free) begin
			if (nxt_v_q) begin
				cur_q <= nxt_q;
				nxt_q <= push_e;
			end else begin
				cur_q <= push_e;
			end
		end else if (in_acc && push) begin
			nxt_q <= push_e;
		end
	end

	always_comb begin
		results.valid      = cur_v_q;
		results.is_status  = cur_q.is_status;
		results.status     = cur_q.is_status ? cur_q.status : b64d_pkg::ST_OK;
		results.last       = sub_q == cur_q.last_idx;
		results.byte_count = cur_q.is_status ? cur_q.base :
			16'(cur_q.base + {14'd0, sub_q} + 16'd1);
		results.data_byte  = 8'd0;
		if (!cur_q.is_status) begin
			unique case (sub_q)
				2'd0:    results.data_byte = cur_q.bytes[23:16];
				2'd1:    results.data_byte = cur_q.bytes[15:8];
				2'd2:    results.data_byte = cur_q.bytes[7:0];
				default: results.data_byte = 8'd0;
			endcase
		end
	end

	a_nxt_behind_cur: assert property (@(posedge clk) disable iff (!arst_n)
		nxt_v_q |-> cur_v_q)
		else $error("waiting record without a record in unpacking");

	a_status_single: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_v_q && cur_q.is_status) |-> (cur_q.last_idx == 2'd0 && sub_q == 2'd0))
		else $error("status record unpacked as more than one result");

	a_stall_holds_sub: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_v_q && !results.ready) |=> (cur_v_q && $stable(sub_q)))
		else $error("result advanced while receiver stalled");

	a_pads_fit_group: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q == b64d_pkg::ST_OK && !stop_q) |-> (pad_q <= {1'b0, pos_q}))
		else $error("pad count exceeds sextets held");

	a_sub_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_v_q |-> (sub_q <= cur_q.last_idx))
		else $error("result index beyond record");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the base64 stream decoder: directed strings, then random ones.
`timescale 1ns / 1ps

module testbench;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS_PER_PHASE = 38;
	localparam logic [6:0] NOT_ALPHABET = 7'd64;

	typedef struct packed {
		logic        is_status;
		logic [7:0]  data_byte;
		logic [2:0]  status;
		logic [15:0] byte_count;
		logic        last;
	} result_t;

	logic clk = 1'b0;
	logic arst_n;

	b64d_char_if chars_ch ();
	b64d_res_if  res_ch ();
	b64d_cfg_if  cfg_ch ();

	base64_stream_decoder i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_ch),
		.results (res_ch),
		.cfg     (cfg_ch)
	);

	// Predicted decoder state
	logic [15:0] capacity;
	logic [23:0] sextets;
	logic [1:0]  group_pos;
	logic [2:0]  pads_seen;
	logic        halted_after_pad;
	logic [2:0]  sticky_status;
	logic [15:0] bytes_done;

	result_t due_results[$];
	int      mismatches;
	int      sent_items;
	int      idle_cycles;
	bit      tx_idle_on;
	bit      rx_idle_on;
	int      rx_hold_cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [6:0] sextet_of(logic [7:0] ch);
		if (ch >= "A" && ch <= "Z") return 7'(ch - "A");
		if (ch >= "a" && ch <= "z") return 7'(ch - "a" + 26);
		if (ch >= "0" && ch <= "9") return 7'(ch - "0" + 52);
		if (ch == "+") return 7'd62;
		if (ch == "/") return 7'd63;
		return NOT_ALPHABET;
	endfunction

	function automatic logic [7:0] alphabet_char(int idx);
		if (idx < 26) return 8'("A" + idx);
		if (idx < 52) return 8'("a" + idx - 26);
		if (idx < 62) return 8'("0" + idx - 52);
		if (idx == 62) return "+";
		return "/";
	endfunction

	function automatic logic [7:0] random_space();
		unique case ($urandom_range(0, 3))
			0: return b64d_pkg::CH_CR;
			1: return b64d_pkg::CH_LF;
			2: return b64d_pkg::CH_SPACE;
			default: return b64d_pkg::CH_TAB;
		endcase
	endfunction

	function automatic void clear_string();
		sextets = '0;
		group_pos = '0;
		pads_seen = '0;
		halted_after_pad = 1'b0;
		sticky_status = b64d_pkg::ST_OK;
		bytes_done = '0;
	endfunction

	// Work out the results one accepted item causes and queue them
	function automatic void decode_step(logic op, logic [7:0] ch);
		result_t     r;
		logic [6:0]  v;
		int          produced;
		if (op == b64d_pkg::OP_FINISH) begin
			r = '0;
			r.is_status = 1'b1;
			r.status = sticky_status;
			if (sticky_status == b64d_pkg::ST_OK && group_pos != 2'd0)
				r.status = b64d_pkg::ST_INCOMPLETE;
			r.byte_count = bytes_done;
			r.last = 1'b1;
			due_results.push_back(r);
			clear_string();
			return;
		end
		if (sticky_status != b64d_pkg::ST_OK || halted_after_pad)
			return;
		if (ch == b64d_pkg::CH_CR || ch == b64d_pkg::CH_LF || ch == b64d_pkg::CH_SPACE
			|| ch == b64d_pkg::CH_TAB)
			return;
		if (ch == b64d_pkg::CH_PAD) begin
			pads_seen = pads_seen + 3'd1;
			v = '0;
		end else begin
			if (pads_seen != 3'd0) begin
				sticky_status = b64d_pkg::ST_DATA_AFTER_PAD;
				return;
			end
			v = sextet_of(ch);
			if (v == NOT_ALPHABET) begin
				sticky_status = b64d_pkg::ST_BAD_CHAR;
				return;
			end
		end
		sextets = {sextets[17:0], v[5:0]};
		if (group_pos != 2'd3) begin
			group_pos = group_pos + 2'd1;
			return;
		end
		group_pos = '0;
		if (pads_seen >= 3'd3) begin
			sticky_status = b64d_pkg::ST_TOO_MANY_PADS;
			return;
		end
		produced = 3 - int'(pads_seen);
		if (int'(bytes_done) + produced > int'(capacity)) begin
			sticky_status = b64d_pkg::ST_CAPACITY;
			return;
		end
		for (int i = 0; i < produced; i++) begin
			bytes_done = bytes_done + 16'd1;
			r = '0;
			r.data_byte = sextets[23 - 8 * i -: 8];
			r.byte_count = bytes_done;
			r.last = (i == produced - 1);
			due_results.push_back(r);
		end
		sextets = '0;
		if (pads_seen != 3'd0)
			halted_after_pad = 1'b1;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Compare every accepted result with the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual status=%0d byte=%0h",
					$time, res_ch.status, res_ch.data_byte);
				mismatches++;
			end else begin
				want = due_results.pop_front();
				check_field("is_status", want.is_status, res_ch.is_status);
				check_field("data_byte", want.data_byte, res_ch.data_byte);
				check_field("status", want.status, res_ch.status);
				check_field("byte_count", want.byte_count, res_ch.byte_count);
				check_field("last", want.last, res_ch.last);
			end
		end
	end

	// End the run when nothing has moved for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((chars_ch.valid && chars_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Result receiver: random stalls per item, plus a long hold-off on request
	initial begin
		int stall;
		res_ch.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold_cycles != 0) begin
				res_ch.ready <= 1'b0;
				repeat (rx_hold_cycles) @(posedge clk);
				rx_hold_cycles = 0;
			end else begin
				stall = rx_idle_on ? $urandom_range(0, 7) : 0;
				if (stall != 0) begin
					res_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid && rx_hold_cycles == 0);
		end
	end

	task automatic send_item(input logic op, input logic [7:0] ch);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 7) : 0;
		if (gap != 0) begin
			chars_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars_ch.valid <= 1'b1;
		chars_ch.op <= op;
		chars_ch.in_char <= ch;
		do @(posedge clk); while (!chars_ch.ready);
		sent_items++;
		decode_step(op, ch);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(b64d_pkg::OP_CHAR, s[i]);
	endtask

	task automatic finish_string();
		send_item(b64d_pkg::OP_FINISH, 8'($urandom_range(0, 255)));
	endtask

	// Hold the sender until every predicted result has arrived
	task automatic wait_idle();
		chars_ch.valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [15:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		capacity = value;
	endtask

	task automatic test_plain_groups();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		send_text("TWFu");
		send_item(b64d_pkg::OP_CHAR, b64d_pkg::CH_TAB);
		send_text("+/9z");
		finish_string();
	endtask

	task automatic test_padding();
		// unused low bits of a padded group go unchecked; later chars are dropped
		send_text("TR==!");
		finish_string();
		send_text("T=A");
		finish_string();
		send_text("A===");
		finish_string();
	endtask

	task automatic test_errors();
		send_item(b64d_pkg::OP_CHAR, 8'h80);
		send_text("AAAA");
		finish_string();
		send_text("TW");
		finish_string();
	endtask

	task automatic test_capacity();
		wait_idle();
		write_capacity(16'd3);
		send_text("AAAAAAAA");
		finish_string();
		wait_idle();
		write_capacity(16'hffff);
	endtask

	task automatic test_backpressure();
		wait_idle();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		rx_hold_cycles = 60;
		send_text("TWFuTWFuTWFuTWFu");
		finish_string();
		wait_idle();
	endtask

	task automatic send_random_string();
		logic [7:0] text[$];
		int groups;
		int kind;
		int npad;
		tx_idle_on = ($urandom_range(0, 3) != 0);
		rx_idle_on = ($urandom_range(0, 3) != 0);
		groups = $urandom_range(0, 4);
		kind = $urandom_range(0, 9);
		repeat (groups * 4) text.push_back(alphabet_char($urandom_range(0, 63)));
		if (groups > 0 && $urandom_range(0, 2) == 0) begin
			npad = $urandom_range(1, 2);
			for (int i = 0; i < npad; i++)
				text[text.size() - 1 - i] = b64d_pkg::CH_PAD;
		end
		// break a share of the strings
		unique case (kind)
			0: text.insert($urandom_range(0, text.size()), 8'($urandom_range(0, 255)));
			1: if (text.size() > 0) void'(text.pop_back());
			2: begin
				text.push_back(alphabet_char($urandom_range(0, 63)));
				repeat (3) text.push_back(b64d_pkg::CH_PAD);
			end
			3: text.push_back(alphabet_char($urandom_range(0, 63)));
			4: if (text.size() > 0) text[$urandom_range(0, text.size() - 1)] = b64d_pkg::CH_PAD;
			default: ;
		endcase
		foreach (text[i]) begin
			if ($urandom_range(0, 7) == 0)
				send_item(b64d_pkg::OP_CHAR, random_space());
			send_item(b64d_pkg::OP_CHAR, text[i]);
		end
		finish_string();
	endtask

	task automatic test_random_strings();
		logic [15:0] settings[5];
		int base;
		settings[0] = 16'd0;
		settings[1] = 16'd1;
		settings[2] = 16'd7;
		settings[3] = 16'($urandom_range(8, 48));
		settings[4] = 16'hffff;
		foreach (settings[p]) begin
			wait_idle();
			write_capacity(settings[p]);
			base = sent_items;
			while (sent_items - base < RANDOM_ITEMS_PER_PHASE)
				send_random_string();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		chars_ch.valid = 1'b0;
		chars_ch.op = b64d_pkg::OP_CHAR;
		chars_ch.in_char = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		mismatches = 0;
		sent_items = 0;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		rx_hold_cycles = 0;
		capacity = 16'hffff;
		clear_string();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_plain_groups();
		test_padding();
		test_errors();
		test_capacity();
		test_backpressure();
		test_random_strings();

		wait_idle();
		repeat (16) @(posedge clk);
		if (mismatches == 0 && due_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
